// ===== hdl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== hdl/gsls_pkg.sv =====
// ---------------------------------------------------------------------------
// gsls_pkg
// Types, codes and arithmetic helpers of the golden-step line search.
// ---------------------------------------------------------------------------
package gsls_pkg;

    typedef logic signed [31:0] q32_t;
    typedef logic signed [33:0] wide_t;
    typedef logic        [30:0] step_t;
    typedef logic        [15:0] iter_t;

    typedef enum logic {
        OP_START    = 1'b0,
        OP_RESPONSE = 1'b1
    } op_t;

    typedef enum logic {
        KIND_REQUEST = 1'b0,
        KIND_DONE    = 1'b1
    } kind_t;

    typedef enum logic [2:0] {
        CFG_SEARCH_MINIMUM  = 3'd0,
        CFG_INITIAL_STEP    = 3'd1,
        CFG_STEP_TOLERANCE  = 3'd2,
        CFG_ITERATION_LIMIT = 3'd3,
        CFG_LOWER_BOUND     = 3'd4,
        CFG_UPPER_BOUND     = 3'd5
    } cfg_index_t;

    typedef enum logic [6:0] {
        PH_IDLE = 7'b0000001,
        PH_F0   = 7'b0000010,
        PH_V1   = 7'b0000100,
        PH_V2   = 7'b0001000,
        PH_L1   = 7'b0010000,
        PH_L2   = 7'b0100000,
        PH_L2I  = 7'b1000000
    } phase_t;

    typedef struct packed {
        op_t  op;
        q32_t start_point;
        q32_t func_value;
    } in_item_t;

    typedef struct packed {
        kind_t kind;
        q32_t  point;
        q32_t  extreme_value;
        logic  interior;
    } out_item_t;

    localparam q32_t Q32_MAX = 32'sh7FFF_FFFF;
    localparam q32_t Q32_MIN = 32'sh8000_0000;

    // step * 500 / 809 == step * 1000 / 1618; reciprocal is floor(2^32 * 500 / 809)
    localparam logic [31:0] SHRINK_RECIP = 32'd2654491530;
    localparam logic [40:0] SHRINK_NUM   = 41'd500;
    localparam logic [40:0] SHRINK_DEN   = 41'd809;
    localparam logic [1:0]  SHRINK_LATENCY = 2'd2;

    localparam step_t RESET_INITIAL_STEP   = 31'd65536;
    localparam step_t RESET_STEP_TOLERANCE = 31'd66;
    localparam iter_t RESET_ITER_LIMIT     = 16'd1000;

    function automatic wide_t ext34(input q32_t v);
        return {{2{v[31]}}, v};
    endfunction

    // Negation for minimum search; the most negative value saturates.
    function automatic q32_t flip(input q32_t v, input logic minimize);
        if (!minimize) begin
            return v;
        end
        if (v == Q32_MIN) begin
            return Q32_MAX;
        end
        return -v;
    endfunction

    function automatic q32_t sat32(input wide_t p);
        if (p > ext34(Q32_MAX)) begin
            return Q32_MAX;
        end
        if (p < ext34(Q32_MIN)) begin
            return Q32_MIN;
        end
        return p[31:0];
    endfunction

    function automatic wide_t offset(input q32_t pos, input step_t s, input logic neg);
        wide_t d;
        d = $signed({3'b000, s});
        return neg ? ext34(pos) - d : ext34(pos) + d;
    endfunction

    function automatic wide_t offset2(input q32_t pos, input step_t s, input logic neg);
        wide_t d;
        d = $signed({2'b00, s, 1'b0});
        return neg ? ext34(pos) - d : ext34(pos) + d;
    endfunction

endpackage

// ===== hdl/gsls_shrink.sv =====
// ---------------------------------------------------------------------------
// gsls_shrink
// Two-stage step shrink: floor(step * 1000 / 1618) by reciprocal multiply
// and one correction step. Output tracks the input through the product and quotient registers.
// ---------------------------------------------------------------------------
module gsls_shrink
    import gsls_pkg::*;
(
    input  logic  clk,
    input  step_t step,
    output step_t shrunk
);

    logic [62:0] prod_reg;
    step_t       s1_reg;
    step_t       q_reg;

    step_t       q_est;
    logic [40:0] num;
    logic [40:0] qd;
    logic [40:0] rem;
    step_t       q_next;

    always_ff @(posedge clk)
    begin
        prod_reg <= 63'(step) * 63'(SHRINK_RECIP);
        s1_reg   <= step;
        q_reg    <= q_next;
    end

    // Estimate is low by at most one.
    always_comb
    begin
        q_est  = prod_reg[62:32];
        num    = 41'(s1_reg) * SHRINK_NUM;
        qd     = 41'(q_est) * SHRINK_DEN;
        rem    = num - qd;
        q_next = (rem >= SHRINK_DEN) ? q_est + 31'd1 : q_est;
    end

    assign shrunk = q_reg;

endmodule

// ===== hdl/golden_step_line_search.sv =====
// The result register loads at the edge that accepts the item beat.
// Throughput: one item per cycle while result_ready is high, except that after
// any change of the step size the input holds ready low while the shrink
// multiplier pipeline settles; this also holds after reset.
// Reset: asynchronous, active low; all but the result register take documented defaults.
// ---------------------------------------------------------------------------
// golden_step_line_search
// Sequencer of a golden-step extremum search against an external evaluator.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module golden_step_line_search
    import gsls_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       cfg_wen,
    input  logic [2:0] cfg_index,
    input  logic [31:0] cfg_data,

    input  logic       item_valid,
    output logic       item_ready,
    input  in_item_t   item,

    output logic       result_valid,
    input  logic       result_ready,
    output out_item_t  result
);

    // configuration
    logic  search_min_reg;
    step_t init_step_reg;
    step_t tol_reg;
    iter_t limit_reg;
    q32_t  lb_reg;
    q32_t  ub_reg;

    // search state
    q32_t   pos_reg,   pos_next;
    q32_t   best_reg,  best_next;
    q32_t   trial_reg, trial_next;
    step_t  step_reg,  step_next;
    logic   dir_reg,   dir_next;
    logic   idir_reg,  idir_next;
    iter_t  iter_reg,  iter_next;
    phase_t phase_reg, phase_next;

    logic [1:0] settle_reg;
    logic       result_valid_reg;
    out_item_t  result_reg;

    step_t      shrunk;
    logic       accept;
    logic       emit;
    out_item_t  res;

    // working values of the shared decision paths
    logic  run_loop1;
    logic  run_inner;
    q32_t  v;
    q32_t  t;
    step_t s;
    logic  d;
    logic  idw;
    iter_t i;
    wide_t p1;

    gsls_shrink u_shrink (
        .clk    (clk),
        .step   (step_reg),
        .shrunk (shrunk)
    );

    assign accept     = item_valid && item_ready;
    assign item_ready = (settle_reg == 2'd0) && (!result_valid_reg || result_ready);

    always_comb
    begin
        pos_next   = pos_reg;
        best_next  = best_reg;
        trial_next = trial_reg;
        step_next  = step_reg;
        dir_next   = dir_reg;
        idir_next  = idir_reg;
        iter_next  = iter_reg;
        phase_next = phase_reg;
        emit       = 1'b0;
        res        = '{kind: KIND_REQUEST, point: '0, extreme_value: '0, interior: 1'b0};
        run_loop1  = 1'b0;
        run_inner  = 1'b0;
        v          = flip(item.func_value, search_min_reg);
        t          = v;
        s          = step_reg;
        d          = dir_reg;
        idw        = idir_reg;
        i          = iter_reg;
        p1         = '0;

        if (accept) begin
            if (item.op == OP_START) begin
                pos_next   = item.start_point;
                step_next  = init_step_reg;
                dir_next   = 1'b0;
                idir_next  = 1'b0;
                iter_next  = '0;
                best_next  = '0;
                trial_next = '0;
                phase_next = PH_F0;
                emit       = 1'b1;
                res.point  = item.start_point;
            end else begin
                unique case (phase_reg)
                    PH_F0:
                    begin
                        best_next  = v;
                        dir_next   = 1'b0;
                        phase_next = PH_V1;
                        emit       = 1'b1;
                        res.point  = sat32(offset(pos_reg, step_reg, 1'b0));
                    end
                    PH_V1:
                    begin
                        trial_next = v;
                        phase_next = PH_V2;
                        emit       = 1'b1;
                        res.point  = sat32(offset(pos_reg, step_reg, 1'b1));
                    end
                    PH_V2:
                    begin
                        d         = v > trial_reg;
                        t         = d ? v : trial_reg;
                        idw       = d;
                        i         = '0;
                        run_loop1 = 1'b1;
                    end
                    PH_L1:
                    begin
                        s         = (v < best_reg && dir_reg == idir_reg) ? shrunk : step_reg;
                        i         = iter_reg + 16'd1;
                        run_loop1 = 1'b1;
                    end
                    PH_L2:
                    begin
                        run_inner = 1'b1;
                    end
                    PH_L2I:
                    begin
                        i         = iter_reg + 16'd1;
                        run_inner = 1'b1;
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end

        if (run_loop1) begin
            trial_next = t;
            iter_next  = i;
            step_next  = s;
            emit       = 1'b1;
            p1         = offset(pos_reg, s, d);
            if (t < best_reg && {1'b0, s} > {tol_reg, 1'b0} && i < limit_reg) begin
                dir_next   = !d;
                idir_next  = idw;
                phase_next = PH_L1;
                res.point  = sat32(offset(pos_reg, s, !d));
            end else begin
                best_next = t;
                dir_next  = d;
                idir_next = idw;
                if (p1 > ext34(ub_reg) || p1 < ext34(lb_reg)) begin
                    pos_next          = (p1 > ext34(ub_reg)) ? ub_reg : lb_reg;
                    phase_next        = PH_IDLE;
                    res.kind          = KIND_DONE;
                    res.point         = pos_next;
                    res.extreme_value = flip(t, search_min_reg);
                end else begin
                    pos_next  = p1[31:0];
                    idir_next = d;
                    if (s > tol_reg && i < limit_reg) begin
                        phase_next = PH_L2;
                        res.point  = sat32(offset2(pos_reg, s, d));
                    end else begin
                        phase_next        = PH_IDLE;
                        res.kind          = KIND_DONE;
                        res.point         = p1[31:0];
                        res.extreme_value = flip(t, search_min_reg);
                        res.interior      = 1'b1;
                    end
                end
            end
        end

        if (run_inner) begin
            trial_next = t;
            iter_next  = i;
            emit       = 1'b1;
            p1         = offset(pos_reg, step_reg, dir_reg);
            if (t > best_reg && i < limit_reg) begin
                idir_next = dir_reg;
                best_next = t;
                if (p1 > ext34(ub_reg) || p1 < ext34(lb_reg)) begin
                    pos_next          = (p1 > ext34(ub_reg)) ? ub_reg : lb_reg;
                    phase_next        = PH_IDLE;
                    res.kind          = KIND_DONE;
                    res.point         = pos_next;
                    res.extreme_value = flip(t, search_min_reg);
                end else begin
                    pos_next   = p1[31:0];
                    phase_next = PH_L2I;
                    res.point  = sat32(offset2(pos_reg, step_reg, dir_reg));
                end
            end else begin
                // shrink once per reversal pair
                s         = (dir_reg == idir_reg) ? shrunk : step_reg;
                step_next = s;
                dir_next  = !dir_reg;
                if (s > tol_reg && i < limit_reg) begin
                    phase_next = PH_L2;
                    res.point  = sat32(offset(pos_reg, s, !dir_reg));
                end else begin
                    phase_next        = PH_IDLE;
                    res.kind          = KIND_DONE;
                    res.point         = pos_reg;
                    res.extreme_value = flip(best_reg, search_min_reg);
                    res.interior      = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            search_min_reg <= 1'b0;
            init_step_reg  <= RESET_INITIAL_STEP;
            tol_reg        <= RESET_STEP_TOLERANCE;
            limit_reg      <= RESET_ITER_LIMIT;
            lb_reg         <= Q32_MIN;
            ub_reg         <= Q32_MAX;
        end else if (cfg_wen) begin
            unique case (cfg_index)
                CFG_SEARCH_MINIMUM:  search_min_reg <= cfg_data[0];
                CFG_INITIAL_STEP:    init_step_reg  <= cfg_data[30:0];
                CFG_STEP_TOLERANCE:  tol_reg        <= cfg_data[30:0];
                CFG_ITERATION_LIMIT: limit_reg      <= cfg_data[15:0];
                CFG_LOWER_BOUND:     lb_reg         <= cfg_data;
                CFG_UPPER_BOUND:     ub_reg         <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg          <= '0;
            best_reg         <= '0;
            trial_reg        <= '0;
            step_reg         <= '0;
            dir_reg          <= 1'b0;
            idir_reg         <= 1'b0;
            iter_reg         <= '0;
            phase_reg        <= PH_IDLE;
            settle_reg       <= SHRINK_LATENCY;
            result_valid_reg <= 1'b0;
        end else begin
            pos_reg   <= pos_next;
            best_reg  <= best_next;
            trial_reg <= trial_next;
            step_reg  <= step_next;
            dir_reg   <= dir_next;
            idir_reg  <= idir_next;
            iter_reg  <= iter_next;
            phase_reg <= phase_next;
            // wait for the shrink pipeline to see the new step
            if (step_next != step_reg) begin
                settle_reg <= SHRINK_LATENCY;
            end else if (settle_reg != 2'd0) begin
                settle_reg <= settle_reg - 2'd1;
            end
            if (emit) begin
                result_valid_reg <= 1'b1;
            end else if (result_ready) begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit) begin
            result_reg <= res;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `ASSERT_IMPLIES(a_accept_settled, clk, rst_n, accept, settle_reg == 2'd0)
    `ASSERT_NEXT(a_step_never_grows, clk, rst_n, accept && item.op == OP_RESPONSE, step_reg <= $past(step_reg))
    `ASSERT_NEXT(a_done_goes_idle, clk, rst_n, emit && res.kind == KIND_DONE, phase_reg == PH_IDLE)

endmodule

// ===== bench/golden_step_line_search_checker.sv =====
// ---------------------------------------------------------------------------
// golden_step_line_search_checker
// Watches the config port and both item channels, tracks the search
// sequencer's state and settings, and compares every result beat with the
// oldest predicted one. Hands the failure count and the number of results
// still owed to the bench top.
// ---------------------------------------------------------------------------
module golden_step_line_search_checker
    import gsls_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_wen,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,

    input  logic        item_valid,
    input  logic        item_ready,
    input  in_item_t    item,

    input  logic        result_valid,
    input  logic        result_ready,
    input  out_item_t   result,

    output int          failures = 0,
    output int          outstanding = 0
);

    // shadow of the register file
    logic   cfg_minimize;
    step_t  cfg_init_step;
    step_t  cfg_tolerance;
    iter_t  cfg_iter_limit;
    q32_t   cfg_lower;
    q32_t   cfg_upper;

    // shadow of the search state
    q32_t   pos;
    q32_t   best_val;
    q32_t   trial_val;
    step_t  step;
    logic   dir_neg;
    logic   start_dir_neg;
    iter_t  iter_cnt;
    phase_t srch_phase;

    out_item_t predicted_results[$];
    out_item_t want_beat;
    int        fail_count = 0;

    // values are compared negated when looking for a minimum
    function automatic q32_t sense(input q32_t v);
        if (!cfg_minimize) begin
            return v;
        end
        if (v == Q32_MIN) begin
            return Q32_MAX;
        end
        return -v;
    endfunction

    function automatic q32_t clamp_point(input longint p);
        if (p > longint'(Q32_MAX)) begin
            return Q32_MAX;
        end
        if (p < longint'(Q32_MIN)) begin
            return Q32_MIN;
        end
        return q32_t'(p);
    endfunction

    function automatic longint probe_point();
        return dir_neg ? longint'(pos) - longint'(step) : longint'(pos) + longint'(step);
    endfunction

    function automatic void push_request(input longint p);
        out_item_t b;
        b.kind          = KIND_REQUEST;
        b.point         = clamp_point(p);
        b.extreme_value = '0;
        b.interior      = 1'b0;
        predicted_results.push_back(b);
    endfunction

    function automatic void push_done(input logic inner);
        out_item_t b;
        srch_phase      = PH_IDLE;
        b.kind          = KIND_DONE;
        b.point         = pos;
        b.extreme_value = sense(best_val);
        b.interior      = inner;
        predicted_results.push_back(b);
    endfunction

    function automatic void shrink_step();
        step = step_t'((longint'(step) * 1000) / 1618);
    endfunction

    // one step along the current direction; 1 when a bound ended the search
    function automatic bit move_or_stop();
        longint p;
        p = probe_point();
        if (p > longint'(cfg_upper)) begin
            pos = cfg_upper;
            push_done(1'b0);
            return 1'b1;
        end
        if (p < longint'(cfg_lower)) begin
            pos = cfg_lower;
            push_done(1'b0);
            return 1'b1;
        end
        pos = q32_t'(p);
        return 1'b0;
    endfunction

    function automatic void outer_decide();
        if (step > cfg_tolerance && iter_cnt < cfg_iter_limit) begin
            srch_phase = PH_L2;
            push_request(probe_point());
        end else begin
            push_done(1'b1);
        end
    endfunction

    function automatic void climb_decide();
        if (trial_val < best_val && longint'(step) > 2 * longint'(cfg_tolerance) &&
            iter_cnt < cfg_iter_limit) begin
            dir_neg    = !dir_neg;
            srch_phase = PH_L1;
            push_request(probe_point());
        end else begin
            best_val = trial_val;
            if (!move_or_stop()) begin
                start_dir_neg = dir_neg;
                outer_decide();
            end
        end
    endfunction

    function automatic void refine_decide();
        if (trial_val > best_val && iter_cnt < cfg_iter_limit) begin
            start_dir_neg = dir_neg;
            best_val      = trial_val;
            if (!move_or_stop()) begin
                srch_phase = PH_L2I;
                push_request(probe_point());
            end
        end else begin
            // shrink once per reversal pair
            if (dir_neg == start_dir_neg) begin
                shrink_step();
            end
            dir_neg = !dir_neg;
            outer_decide();
        end
    endfunction

    function automatic void predict_search_step(input in_item_t it);
        q32_t v;
        if (it.op == OP_START) begin
            pos           = it.start_point;
            step          = cfg_init_step;
            dir_neg       = 1'b0;
            start_dir_neg = 1'b0;
            iter_cnt      = '0;
            best_val      = '0;
            trial_val     = '0;
            srch_phase    = PH_F0;
            push_request(longint'(pos));
            return;
        end
        v = sense(it.func_value);
        case (srch_phase)
            PH_F0: begin
                best_val   = v;
                dir_neg    = 1'b0;
                srch_phase = PH_V1;
                push_request(longint'(pos) + longint'(step));
            end
            PH_V1: begin
                trial_val  = v;
                srch_phase = PH_V2;
                push_request(longint'(pos) - longint'(step));
            end
            PH_V2: begin
                if (v > trial_val) begin
                    dir_neg   = 1'b1;
                    trial_val = v;
                end else begin
                    dir_neg = 1'b0;
                end
                iter_cnt      = '0;
                start_dir_neg = dir_neg;
                climb_decide();
            end
            PH_L1: begin
                trial_val = v;
                if (v < best_val && dir_neg == start_dir_neg) begin
                    shrink_step();
                end
                iter_cnt = iter_cnt + 1'b1;
                climb_decide();
            end
            PH_L2: begin
                trial_val = v;
                refine_decide();
            end
            PH_L2I: begin
                trial_val = v;
                iter_cnt  = iter_cnt + 1'b1;
                refine_decide();
            end
            default: begin
                // response with no search running: dropped
                srch_phase = PH_IDLE;
            end
        endcase
    endfunction

    function automatic int field_mismatch(input string tag, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want === got) begin
            return 0;
        end
        $display("%0t: %s mismatch, expected %h, actual %h", $time, tag, want, got);
        return 1;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cfg_minimize   = 1'b0;
            cfg_init_step  = RESET_INITIAL_STEP;
            cfg_tolerance  = RESET_STEP_TOLERANCE;
            cfg_iter_limit = RESET_ITER_LIMIT;
            cfg_lower      = Q32_MIN;
            cfg_upper      = Q32_MAX;
            pos            = '0;
            best_val       = '0;
            trial_val      = '0;
            step           = '0;
            dir_neg        = 1'b0;
            start_dir_neg  = 1'b0;
            iter_cnt       = '0;
            srch_phase     = PH_IDLE;
            predicted_results.delete();
            fail_count     = 0;
            failures    <= 0;
            outstanding <= 0;
        end else begin
            // result beat first: it always belongs to an older item
            if (result_valid && result_ready) begin
                if (predicted_results.size() == 0) begin
                    $display("%0t: result beat with nothing pending, expected none, actual %h",
                             $time, result);
                    fail_count++;
                end else begin
                    want_beat = predicted_results.pop_front();
                    fail_count += field_mismatch("kind", want_beat.kind, result.kind);
                    fail_count += field_mismatch("point", want_beat.point, result.point);
                    fail_count += field_mismatch("extreme_value", want_beat.extreme_value,
                                                 result.extreme_value);
                    fail_count += field_mismatch("interior", want_beat.interior,
                                                 result.interior);
                end
            end
            if (item_valid && item_ready) begin
                predict_search_step(item);
            end
            if (cfg_wen) begin
                case (cfg_index)
                    CFG_SEARCH_MINIMUM:  cfg_minimize   = cfg_data[0];
                    CFG_INITIAL_STEP:    cfg_init_step  = cfg_data[30:0];
                    CFG_STEP_TOLERANCE:  cfg_tolerance  = cfg_data[30:0];
                    CFG_ITERATION_LIMIT: cfg_iter_limit = cfg_data[15:0];
                    CFG_LOWER_BOUND:     cfg_lower      = cfg_data;
                    CFG_UPPER_BOUND:     cfg_upper      = cfg_data;
                    default: ;
                endcase
            end
            failures    <= fail_count;
            outstanding <= predicted_results.size();
        end
    end

endmodule

// ===== bench/golden_step_line_search_tb.sv =====
// ---------------------------------------------------------------------------
// golden_step_line_search_tb
// Plays the external function evaluator against the search sequencer:
// a directed pass over extreme points, saturating values, clamped bounds and
// abandoned searches, then randomized settings with smooth hill or bowl
// functions, some with random noise, under several idle and stall patterns.
// Checking is done by the checker instance beside the block.
// ---------------------------------------------------------------------------
module golden_step_line_search_tb;
    import gsls_pkg::*;

    localparam int          RANDOM_PHASES   = 8;
    localparam int          ITEMS_PER_PHASE = 215;
    localparam int          SEARCH_CAP      = 150;
    localparam int          MAX_GAP         = 40;
    localparam logic [2:0]  CFG_SPARE_INDEX = 3'd7;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wen = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        item_valid = 1'b0;
    logic        item_ready;
    in_item_t    item = '0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    out_item_t   result;
    int          failures;
    int          outstanding;

    int          sender_idle_pct = 0;
    int          receiver_stall_pct = 0;
    q32_t        cur_lower = Q32_MIN;
    q32_t        cur_upper = Q32_MAX;

    // shape of the function the bench evaluates
    longint      fn_center;
    int          fn_shift;
    longint      fn_peak;
    bit          fn_bowl;
    int          fn_noise_pct;

    int          phase_no;
    int          items_left;

    golden_step_line_search uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wen      (cfg_wen),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    golden_step_line_search_checker chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wen      (cfg_wen),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .failures     (failures),
        .outstanding  (outstanding)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        result_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    function automatic q32_t to_q32(input longint v);
        if (v > longint'(Q32_MAX)) begin
            return Q32_MAX;
        end
        if (v < longint'(Q32_MIN)) begin
            return Q32_MIN;
        end
        return q32_t'(v);
    endfunction

    function automatic q32_t eval_f(input q32_t x);
        longint d;
        longint sq;
        if ($urandom_range(99) < fn_noise_pct) begin
            return q32_t'($urandom);
        end
        d = (longint'(x) - fn_center) >>> fn_shift;
        if (d > 2147483647) begin
            d = 2147483647;
        end
        if (d < -2147483647) begin
            d = -2147483647;
        end
        sq = (d * d) >>> 16;
        return to_q32(fn_bowl ? fn_peak + sq : fn_peak - sq);
    endfunction

    function automatic in_item_t start_beat(input q32_t p);
        in_item_t it;
        it.op          = OP_START;
        it.start_point = p;
        it.func_value  = q32_t'($urandom);
        return it;
    endfunction

    function automatic in_item_t value_beat(input q32_t v);
        in_item_t it;
        it.op          = OP_RESPONSE;
        it.start_point = q32_t'($urandom);
        it.func_value  = v;
        return it;
    endfunction

    // leaves valid high; the caller lowers it when no beat follows at once
    task automatic send_item(input in_item_t it);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item       <= it;
        item_valid <= 1'b1;
        @(posedge clk);
        while (!item_ready) begin
            @(posedge clk);
        end
    endtask

    task automatic send_and_await(input in_item_t it, output out_item_t r);
        send_item(it);
        item_valid <= 1'b0;
        @(posedge clk);
        while (!(result_valid && result_ready)) begin
            @(posedge clk);
        end
        r = result;
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] data);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        if (idx == CFG_LOWER_BOUND) begin
            cur_lower = data;
        end
        if (idx == CFG_UPPER_BOUND) begin
            cur_upper = data;
        end
        @(posedge clk);
    endtask

    // hold off until every result is back, plus slack for the shrink pipeline
    task automatic settle();
        @(posedge clk);
        while (outstanding != 0) begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic configure_random();
        logic [31:0] w;
        q32_t        lo;
        q32_t        hi;
        q32_t        t;
        int          reach;
        w    = $urandom;
        w[0] = 1'($urandom_range(1));
        cfg_write(CFG_SEARCH_MINIMUM, w);
        w = $urandom;
        case ($urandom_range(9))
            0: w[30:0] = '0;
            1: w[30:0] = '1;
            2: ;
            default: w[30:0] = 31'($urandom_range(1 << 20, 1));
        endcase
        cfg_write(CFG_INITIAL_STEP, w);
        w = $urandom;
        case ($urandom_range(9))
            0: w[30:0] = '0;
            1: w[30:0] = '1;
            2: ;
            3: w[30:0] = RESET_STEP_TOLERANCE;
            default: w[30:0] = 31'($urandom_range(2000));
        endcase
        cfg_write(CFG_STEP_TOLERANCE, w);
        w = $urandom;
        case ($urandom_range(7))
            0: w[15:0] = '0;
            1: w[15:0] = '1;
            2: w[15:0] = 16'd1;
            default: w[15:0] = 16'($urandom_range(3000, 2));
        endcase
        cfg_write(CFG_ITERATION_LIMIT, w);
        case ($urandom_range(5))
            3: begin
                lo = q32_t'($urandom);
                hi = q32_t'($urandom);
                if (lo > hi) begin
                    t  = lo;
                    lo = hi;
                    hi = t;
                end
            end
            4: begin
                // possibly inverted window
                lo = q32_t'($urandom);
                hi = q32_t'($urandom);
            end
            5: begin
                reach = $urandom_range(1 << 30, 1 << 16);
                lo    = -reach;
                hi    = reach;
            end
            default: begin
                lo = Q32_MIN;
                hi = Q32_MAX;
            end
        endcase
        cfg_write(CFG_LOWER_BOUND, lo);
        cfg_write(CFG_UPPER_BOUND, hi);
        cfg_wen <= 1'b0;
    endtask

    // one search: start beat, then answer each request until done or cut off
    task automatic run_search(inout int left);
        out_item_t r;
        q32_t      sp;
        longint    span;
        longint    off;
        int        responses;
        if (cur_lower <= cur_upper) begin
            span      = longint'(cur_upper) - longint'(cur_lower);
            fn_center = longint'(cur_lower) + longint'($urandom_range(32'(span)));
        end else begin
            fn_center = longint'(q32_t'($urandom));
        end
        fn_shift     = ($urandom_range(9) == 0) ? 40 : $urandom_range(12);
        fn_peak      = longint'(q32_t'($urandom)) >>> $urandom_range(8);
        fn_bowl      = 1'($urandom_range(1));
        fn_noise_pct = ($urandom_range(3) == 0) ? 5 : 0;
        case ($urandom_range(9))
            0: sp = Q32_MAX;
            1: sp = Q32_MIN;
            2: sp = q32_t'($urandom);
            default: begin
                off = longint'(q32_t'($urandom)) >>> $urandom_range(24, 4);
                sp  = to_q32(fn_center + off);
            end
        endcase
        send_and_await(start_beat(sp), r);
        left--;
        responses = 0;
        // a cut-off search is abandoned by the next start beat
        while (r.kind == KIND_REQUEST && left > 0 && responses < SEARCH_CAP &&
               $urandom_range(199) != 0) begin
            send_and_await(value_beat(eval_f(r.point)), r);
            left--;
            responses++;
        end
        // stray response after the end: no result
        if (r.kind == KIND_DONE && $urandom_range(7) == 0) begin
            send_item(value_beat(q32_t'($urandom)));
        end
    endtask

    initial
    begin
        #20_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // defaults: maximize, full bounds
        send_item(value_beat(32'sd12345));
        send_item(start_beat(32'sd0));
        send_item(value_beat(Q32_MIN));
        send_item(value_beat(Q32_MAX));
        send_item(value_beat(32'sd0));
        // restart mid-search near the top, then run into the upper bound
        send_item(start_beat(Q32_MAX));
        send_item(value_beat(32'sd5));
        send_item(value_beat(32'sd7));
        send_item(value_beat(32'sd3));
        send_item(start_beat(Q32_MIN));
        send_item(value_beat(32'sd9));
        send_item(value_beat(32'sd1));
        send_item(value_beat(32'sd4));
        send_item(value_beat(32'sd2));
        item_valid <= 1'b0;
        settle();

        // minimize, widest step, no tolerance, no iterations, narrow window
        cfg_write(CFG_SEARCH_MINIMUM, 32'hFFFF_FFFF);
        cfg_write(CFG_INITIAL_STEP, 32'hFFFF_FFFF);
        cfg_write(CFG_STEP_TOLERANCE, 32'h8000_0000);
        cfg_write(CFG_ITERATION_LIMIT, 32'hFFFF_0000);
        cfg_write(CFG_LOWER_BOUND, 32'hFF9C_0000);
        cfg_write(CFG_UPPER_BOUND, 32'h0064_0000);
        cfg_write(CFG_SPARE_INDEX, 32'h5A5A_A5A5);
        cfg_wen <= 1'b0;
        send_item(start_beat(32'sd0));
        send_item(value_beat(Q32_MIN));
        send_item(value_beat(Q32_MAX));
        send_item(value_beat(-32'sd5));
        item_valid <= 1'b0;
        settle();

        // zero step, tolerance at max, inverted bounds
        cfg_write(CFG_SEARCH_MINIMUM, 32'hFFFF_FFFE);
        cfg_write(CFG_INITIAL_STEP, 32'h8000_0000);
        cfg_write(CFG_STEP_TOLERANCE, 32'h7FFF_FFFF);
        cfg_write(CFG_ITERATION_LIMIT, 32'h0000_FFFF);
        cfg_write(CFG_LOWER_BOUND, Q32_MAX);
        cfg_write(CFG_UPPER_BOUND, Q32_MIN);
        cfg_wen <= 1'b0;
        send_item(start_beat(-32'sd1));
        send_item(value_beat(32'sd10));
        send_item(value_beat(32'sd20));
        send_item(value_beat(32'sd30));
        item_valid <= 1'b0;
        settle();

        // unit step, zero tolerance, one iteration
        cfg_write(CFG_INITIAL_STEP, 32'd1);
        cfg_write(CFG_STEP_TOLERANCE, 32'd0);
        cfg_write(CFG_ITERATION_LIMIT, 32'd1);
        cfg_write(CFG_LOWER_BOUND, Q32_MIN);
        cfg_write(CFG_UPPER_BOUND, Q32_MAX);
        cfg_wen <= 1'b0;
        send_item(start_beat(q32_t'($urandom)));
        send_item(value_beat(q32_t'($urandom)));
        send_item(value_beat(q32_t'($urandom)));
        send_item(value_beat(q32_t'($urandom)));
        item_valid <= 1'b0;
        settle();

        for (phase_no = 0; phase_no < RANDOM_PHASES; phase_no++) begin
            case (phase_no % 4)
                0: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
                1: begin
                    sender_idle_pct    = 75;
                    receiver_stall_pct = 0;
                end
                2: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 75;
                end
                default: begin
                    sender_idle_pct    = 7;
                    receiver_stall_pct = 7;
                end
            endcase
            configure_random();
            items_left = ITEMS_PER_PHASE;
            while (items_left > 0) begin
                run_search(items_left);
            end
            item_valid <= 1'b0;
            settle();
        end

        repeat (8) @(posedge clk);
        if (failures == 0 && outstanding == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
